@@ sv/mmlp_pkg.sv @@
// Package for the memory-map line parser: payload types, character codes,
// the field phase type and the hex digit decode. Depends on nothing.
package mmlp_pkg;

    localparam int LINE_INDEX_BITS_DEF = 16;
    localparam int LINE_INDEX_W        = 16;
    localparam int ADDR_W              = 64;
    localparam int CHAR_W              = 8;
    localparam int DIGIT_W             = 4;

    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_R       = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W       = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_END   = 2'd1,
        PH_PERM  = 2'd2,
        PH_REST  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
    } t_char_item;

    typedef struct packed {
        logic [LINE_INDEX_W-1:0] line_index;
        logic [ADDR_W-1:0]       start_address;
        logic [ADDR_W-1:0]       end_address;
        logic [ADDR_W-1:0]       region_size;
        logic                    readable;
        logic                    writeable;
        logic                    executable;
    } t_line_item;

    // lowercase hex only; anything else decodes as zero
    function automatic logic [DIGIT_W-1:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = DIGIT_W'(c - 8'h57);
        end
        return d;
    endfunction

endpackage

@@ sv/mmlp_stream_if.sv @@
// Valid/ready stream interface used for both the character input and the
// line result output. Payload type is a parameter; types come from mmlp_pkg.
interface mmlp_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/mmlp_parse_core.sv @@
// Per-line parse state: field phase, address accumulators, permission flags
// and the line counter. Advances one character per step. Uses mmlp_pkg.
module mmlp_parse_core
    import mmlp_pkg::*;
#(
    parameter int LINE_INDEX_BITS = LINE_INDEX_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    output t_line_item        o_line
);

    t_phase                     r_phase, n_phase;
    logic [ADDR_W-1:0]          r_start, n_start;
    logic [ADDR_W-1:0]          r_end, n_end;
    logic [1:0]                 r_pos, n_pos;
    logic [2:0]                 r_flags, n_flags;
    logic [LINE_INDEX_BITS-1:0] r_line_cnt, n_line_cnt;

    logic w_is_nl;
    logic w_is_delim;

    assign w_is_nl    = (i_char == CH_NEWLINE);
    assign w_is_delim = (i_char == CH_DASH) || (i_char == CH_SPACE);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_is_nl) begin
            n_phase = PH_START;
        end else begin
            case (r_phase)
                PH_START: if (w_is_delim) n_phase = PH_END;
                PH_END:   if (w_is_delim) n_phase = PH_PERM;
                PH_PERM:  if (r_pos == 2'd2) n_phase = PH_REST;
                default:  n_phase = r_phase;
            endcase
        end
    end

    // datapath updates
    always_comb begin
        n_start    = r_start;
        n_end      = r_end;
        n_pos      = r_pos;
        n_flags    = r_flags;
        n_line_cnt = r_line_cnt;
        if (w_is_nl) begin
            n_start    = '0;
            n_end      = '0;
            n_pos      = '0;
            n_flags    = '0;
            n_line_cnt = r_line_cnt + 1'b1;
        end else begin
            case (r_phase)
                PH_START: begin
                    // shift-add by one hex digit is a nibble append
                    if (!w_is_delim) n_start = {r_start[ADDR_W-DIGIT_W-1:0], hex_digit(i_char)};
                end
                PH_END: begin
                    if (w_is_delim) n_pos = '0;
                    else n_end = {r_end[ADDR_W-DIGIT_W-1:0], hex_digit(i_char)};
                end
                PH_PERM: begin
                    if (r_pos == 2'd0 && i_char == CH_R) n_flags[0] = 1'b1;
                    if (r_pos == 2'd1 && i_char == CH_W) n_flags[1] = 1'b1;
                    if (r_pos == 2'd2 && i_char == CH_X) n_flags[2] = 1'b1;
                    n_pos = r_pos + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_start    <= '0;
            r_end      <= '0;
            r_pos      <= '0;
            r_flags    <= '0;
            r_line_cnt <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_start    <= n_start;
            r_end      <= n_end;
            r_pos      <= n_pos;
            r_flags    <= n_flags;
            r_line_cnt <= n_line_cnt;
        end
    end

    always_comb begin
        o_line.line_index    = LINE_INDEX_W'(r_line_cnt);
        o_line.start_address = r_start;
        o_line.end_address   = r_end;
        o_line.region_size   = r_end - r_start;
        o_line.readable      = r_flags[0];
        o_line.writeable     = r_flags[1];
        o_line.executable    = r_flags[2];
    end

endmodule

@@ sv/memory_map_line_parser.sv @@
// Memory-map line parser. Takes one ASCII character per transfer on i_char
// and emits one line record on o_line for every newline: line index, start
// and end address (lowercase hex, other characters read as digit 0), size
// and the r/w/x flags. Throughput is one character per clock; a character
// is held in the input register before it updates the parse state, and a
// line record is registered in the output register when its newline is
// processed from the input register. The input stalls only when a newline
// waits while the output register is still full and not being taken.
// Depends on mmlp_pkg, mmlp_stream_if and mmlp_parse_core.
module memory_map_line_parser
    import mmlp_pkg::*;
#(
    parameter int LINE_INDEX_BITS = LINE_INDEX_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmlp_stream_if.sink   i_char,
    mmlp_stream_if.source o_line
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_out_valid;
    t_line_item        r_out;
    t_line_item        w_line;

    logic w_in_xfer;
    logic w_out_free;
    logic w_is_nl;
    logic w_step;

    assign w_in_xfer  = i_char.valid && i_char.ready;
    assign w_out_free = !r_out_valid || o_line.ready;
    assign w_is_nl    = (r_char == CH_NEWLINE);
    assign w_step     = r_in_valid && (!w_is_nl || w_out_free);

    assign i_char.ready   = !r_in_valid || w_step;
    assign o_line.valid   = r_out_valid;
    assign o_line.payload = r_out;

    mmlp_parse_core #(
        .LINE_INDEX_BITS(LINE_INDEX_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_char (r_char),
        .o_line (w_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) r_in_valid <= 1'b1;
            else if (w_step) r_in_valid <= 1'b0;

            if (w_step && w_is_nl) r_out_valid <= 1'b1;
            else if (o_line.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) r_char <= i_char.payload.char_code;
        if (w_step && w_is_nl) r_out <= w_line;
    end

    // a record only appears after a newline was processed
    a_out_from_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && w_is_nl))
        else $error("line record without newline");

    // input stalls only behind a newline blocked by a full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> (r_in_valid && w_is_nl && r_out_valid && !o_line.ready))
        else $error("input stalled without cause");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.region_size == r_out.end_address - r_out.start_address))
        else $error("region size mismatch");

endmodule
